// ===== hdl/btgb_pkg.sv =====
// ----------------------------------------------------------------------------
// btgb_pkg
// Shared types, constants and the 5x9 glyph ROM of the text glyph blitter.
// ----------------------------------------------------------------------------
package btgb_pkg;

   // Glyph geometry and cursor steps.
   localparam int GLYPH_ROWS    = 9;
   localparam int GLYPH_COLS    = 5;
   localparam int GLYPH_BITS_W  = GLYPH_ROWS * GLYPH_COLS;
   localparam int TAB_STEP      = 16;   // must be a power of two
   localparam int LINE_ADVANCE  = 10;
   localparam int SPACE_ADVANCE = 4;
   localparam int COORD_W       = 16;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CLIP_WIDTH    = 2'd2;

   // Register reset values.
   localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd640;
   localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd480;
   localparam logic [4:0]  CLIP_WIDTH_RESET    = 5'd5;

   // Control characters that move the cursor without drawing.
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef struct packed {
      logic [2:0]              width;
      logic [GLYPH_BITS_W-1:0] bits;
   } glyph_type;

   typedef struct packed {
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [4:0]  clip_width;
   } cfg_type;

   typedef struct packed {
      logic               new_message;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic               shadow;
      logic [7:0]         character;
   } req_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] cursor_x;
      logic [COORD_W-1:0] cursor_y;
      logic [COORD_W-1:0] line_start_x;
   } cursor_type;

   // Everything the sequencer needs to send the blits of one character.
   typedef struct packed {
      glyph_type          glyph;
      logic [COORD_W-1:0] main_x;
      logic [COORD_W-1:0] main_y;
      logic [COORD_W-1:0] shadow_x;
      logic [COORD_W-1:0] shadow_y;
      logic               main_visible;
      logic               shadow_visible;
      cursor_type         next_cursor;
   } plan_type;

   typedef struct packed {
      logic [COORD_W-1:0]      blit_x;
      logic [COORD_W-1:0]      blit_y;
      logic [GLYPH_BITS_W-1:0] glyph_bits;
      logic [2:0]              glyph_width;
      logic [7:0]              draw_red;
      logic [7:0]              draw_green;
      logic [7:0]              draw_blue;
      logic                    last;
   } blit_type;

   // Builds one glyph from its rows, top row first.
   function automatic glyph_type make_glyph(
      input logic [2:0] w,
      input logic [4:0] r0, input logic [4:0] r1, input logic [4:0] r2,
      input logic [4:0] r3, input logic [4:0] r4, input logic [4:0] r5,
      input logic [4:0] r6, input logic [4:0] r7, input logic [4:0] r8);
      glyph_type g;
      g.width = w;
      g.bits  = {r8, r7, r6, r5, r4, r3, r2, r1, r0};
      return g;
   endfunction

   // Glyph ROM. Codes without a glyph show the question mark.
   function automatic glyph_type glyph_lookup(input logic [7:0] c);
      glyph_type g;
      case (c)
         // Upper case.
         8'h41: g = make_glyph(3'd4, 5'h0c,5'h12,5'h12,5'h12,5'h1e,5'h12,5'h12,5'h00,5'h00);
         8'h42: g = make_glyph(3'd4, 5'h1c,5'h12,5'h12,5'h1c,5'h12,5'h12,5'h1c,5'h00,5'h00);
         8'h43: g = make_glyph(3'd4, 5'h0e,5'h10,5'h10,5'h10,5'h10,5'h10,5'h0e,5'h00,5'h00);
         8'h44: g = make_glyph(3'd4, 5'h1c,5'h12,5'h12,5'h12,5'h12,5'h12,5'h1c,5'h00,5'h00);
         8'h45: g = make_glyph(3'd4, 5'h1e,5'h10,5'h10,5'h1c,5'h10,5'h10,5'h1e,5'h00,5'h00);
         8'h46: g = make_glyph(3'd4, 5'h1e,5'h10,5'h10,5'h1c,5'h10,5'h10,5'h10,5'h00,5'h00);
         8'h47: g = make_glyph(3'd4, 5'h0e,5'h10,5'h10,5'h10,5'h16,5'h12,5'h0e,5'h00,5'h00);
         8'h48: g = make_glyph(3'd4, 5'h12,5'h12,5'h12,5'h1e,5'h12,5'h12,5'h12,5'h00,5'h00);
         8'h49: g = make_glyph(3'd3, 5'h1c,5'h08,5'h08,5'h08,5'h08,5'h08,5'h1c,5'h00,5'h00);
         8'h4A: g = make_glyph(3'd4, 5'h1e,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0c,5'h00,5'h00);
         8'h4B: g = make_glyph(3'd4, 5'h10,5'h12,5'h14,5'h18,5'h18,5'h14,5'h12,5'h00,5'h00);
         8'h4C: g = make_glyph(3'd4, 5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1e,5'h00,5'h00);
         8'h4D: g = make_glyph(3'd5, 5'h11,5'h1b,5'h15,5'h11,5'h11,5'h11,5'h11,5'h00,5'h00);
         8'h4E: g = make_glyph(3'd5, 5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h00,5'h00);
         8'h4F: g = make_glyph(3'd4, 5'h0c,5'h12,5'h12,5'h12,5'h12,5'h12,5'h0c,5'h00,5'h00);
         8'h50: g = make_glyph(3'd4, 5'h1c,5'h12,5'h12,5'h12,5'h1c,5'h10,5'h10,5'h00,5'h00);
         8'h51: g = make_glyph(3'd4, 5'h0c,5'h12,5'h12,5'h12,5'h12,5'h16,5'h0c,5'h02,5'h00);
         8'h52: g = make_glyph(3'd4, 5'h1c,5'h12,5'h12,5'h12,5'h1c,5'h14,5'h12,5'h00,5'h00);
         8'h53: g = make_glyph(3'd4, 5'h0c,5'h12,5'h10,5'h08,5'h04,5'h12,5'h0c,5'h00,5'h00);
         8'h54: g = make_glyph(3'd3, 5'h1c,5'h08,5'h08,5'h08,5'h08,5'h08,5'h08,5'h00,5'h00);
         8'h55: g = make_glyph(3'd4, 5'h12,5'h12,5'h12,5'h12,5'h12,5'h12,5'h0c,5'h00,5'h00);
         8'h56: g = make_glyph(3'd4, 5'h12,5'h12,5'h12,5'h12,5'h12,5'h0a,5'h06,5'h00,5'h00);
         8'h57: g = make_glyph(3'd5, 5'h11,5'h11,5'h11,5'h11,5'h15,5'h1b,5'h11,5'h00,5'h00);
         8'h58: g = make_glyph(3'd5, 5'h11,5'h11,5'h0a,5'h04,5'h0a,5'h11,5'h11,5'h00,5'h00);
         8'h59: g = make_glyph(3'd4, 5'h12,5'h12,5'h12,5'h0a,5'h06,5'h04,5'h18,5'h00,5'h00);
         8'h5A: g = make_glyph(3'd4, 5'h1e,5'h02,5'h02,5'h04,5'h08,5'h10,5'h1e,5'h00,5'h00);
         // Lower case.
         8'h61: g = make_glyph(3'd4, 5'h00,5'h00,5'h0c,5'h02,5'h0e,5'h12,5'h0e,5'h00,5'h00);
         8'h62: g = make_glyph(3'd4, 5'h00,5'h10,5'h1c,5'h12,5'h12,5'h12,5'h1c,5'h00,5'h00);
         8'h63: g = make_glyph(3'd3, 5'h00,5'h00,5'h0c,5'h10,5'h10,5'h10,5'h0c,5'h00,5'h00);
         8'h64: g = make_glyph(3'd4, 5'h00,5'h02,5'h0e,5'h12,5'h12,5'h12,5'h0e,5'h00,5'h00);
         8'h65: g = make_glyph(3'd4, 5'h00,5'h00,5'h0c,5'h12,5'h1e,5'h10,5'h0e,5'h00,5'h00);
         8'h66: g = make_glyph(3'd3, 5'h00,5'h0c,5'h10,5'h10,5'h18,5'h10,5'h10,5'h00,5'h00);
         8'h67: g = make_glyph(3'd4, 5'h00,5'h00,5'h0e,5'h12,5'h12,5'h12,5'h0e,5'h02,5'h0c);
         8'h68: g = make_glyph(3'd4, 5'h00,5'h10,5'h10,5'h1c,5'h12,5'h12,5'h12,5'h00,5'h00);
         8'h69: g = make_glyph(3'd2, 5'h00,5'h08,5'h00,5'h18,5'h08,5'h08,5'h08,5'h00,5'h00);
         8'h6A: g = make_glyph(3'd2, 5'h00,5'h08,5'h00,5'h18,5'h08,5'h08,5'h08,5'h08,5'h10);
         8'h6B: g = make_glyph(3'd3, 5'h00,5'h10,5'h10,5'h10,5'h14,5'h18,5'h14,5'h00,5'h00);
         8'h6C: g = make_glyph(3'd2, 5'h00,5'h18,5'h08,5'h08,5'h08,5'h08,5'h08,5'h00,5'h00);
         8'h6D: g = make_glyph(3'd5, 5'h00,5'h00,5'h1a,5'h15,5'h11,5'h11,5'h11,5'h00,5'h00);
         8'h6E: g = make_glyph(3'd4, 5'h00,5'h00,5'h1c,5'h12,5'h12,5'h12,5'h12,5'h00,5'h00);
         8'h6F: g = make_glyph(3'd4, 5'h00,5'h00,5'h0c,5'h12,5'h12,5'h12,5'h0c,5'h00,5'h00);
         8'h70: g = make_glyph(3'd4, 5'h00,5'h00,5'h1c,5'h12,5'h12,5'h12,5'h1c,5'h10,5'h10);
         8'h71: g = make_glyph(3'd4, 5'h00,5'h00,5'h0e,5'h12,5'h12,5'h12,5'h0e,5'h03,5'h02);
         8'h72: g = make_glyph(3'd4, 5'h00,5'h00,5'h16,5'h18,5'h10,5'h10,5'h10,5'h00,5'h00);
         8'h73: g = make_glyph(3'd4, 5'h00,5'h00,5'h0e,5'h10,5'h0c,5'h02,5'h1c,5'h00,5'h00);
         8'h74: g = make_glyph(3'd3, 5'h00,5'h10,5'h10,5'h1c,5'h10,5'h10,5'h0c,5'h00,5'h00);
         8'h75: g = make_glyph(3'd4, 5'h00,5'h00,5'h12,5'h12,5'h12,5'h12,5'h0e,5'h00,5'h00);
         8'h76: g = make_glyph(3'd4, 5'h00,5'h00,5'h12,5'h12,5'h12,5'h0a,5'h06,5'h00,5'h00);
         8'h77: g = make_glyph(3'd5, 5'h00,5'h00,5'h11,5'h11,5'h11,5'h15,5'h0a,5'h00,5'h00);
         8'h78: g = make_glyph(3'd5, 5'h00,5'h00,5'h11,5'h0a,5'h04,5'h0a,5'h11,5'h00,5'h00);
         8'h79: g = make_glyph(3'd4, 5'h00,5'h00,5'h12,5'h12,5'h12,5'h12,5'h0e,5'h02,5'h0c);
         8'h7A: g = make_glyph(3'd4, 5'h00,5'h00,5'h1e,5'h02,5'h04,5'h08,5'h1e,5'h00,5'h00);
         // Digits.
         8'h30: g = make_glyph(3'd4, 5'h0c,5'h12,5'h16,5'h1a,5'h12,5'h12,5'h0c,5'h00,5'h00);
         8'h31: g = make_glyph(3'd3, 5'h08,5'h18,5'h08,5'h08,5'h08,5'h08,5'h1c,5'h00,5'h00);
         8'h32: g = make_glyph(3'd4, 5'h0c,5'h12,5'h02,5'h04,5'h08,5'h10,5'h1e,5'h00,5'h00);
         8'h33: g = make_glyph(3'd4, 5'h0c,5'h12,5'h02,5'h04,5'h02,5'h12,5'h0c,5'h00,5'h00);
         8'h34: g = make_glyph(3'd4, 5'h04,5'h0c,5'h14,5'h14,5'h1e,5'h04,5'h04,5'h00,5'h00);
         8'h35: g = make_glyph(3'd4, 5'h1e,5'h10,5'h10,5'h1c,5'h02,5'h02,5'h1c,5'h00,5'h00);
         8'h36: g = make_glyph(3'd4, 5'h04,5'h08,5'h10,5'h1c,5'h12,5'h12,5'h0c,5'h00,5'h00);
         8'h37: g = make_glyph(3'd4, 5'h1e,5'h02,5'h02,5'h04,5'h08,5'h08,5'h08,5'h00,5'h00);
         8'h38: g = make_glyph(3'd4, 5'h0c,5'h12,5'h12,5'h0c,5'h12,5'h12,5'h0c,5'h00,5'h00);
         8'h39: g = make_glyph(3'd4, 5'h0c,5'h12,5'h12,5'h0e,5'h02,5'h02,5'h0c,5'h00,5'h00);
         // Punctuation.
         8'h2E: g = make_glyph(3'd1, 5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h10,5'h00,5'h00);
         8'h2C: g = make_glyph(3'd2, 5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h10,5'h10,5'h00);
         8'h21: g = make_glyph(3'd1, 5'h10,5'h10,5'h10,5'h10,5'h10,5'h00,5'h10,5'h00,5'h00);
         8'h22: g = make_glyph(3'd3, 5'h14,5'h14,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00);
         8'h28: g = make_glyph(3'd2, 5'h00,5'h08,5'h10,5'h10,5'h10,5'h10,5'h08,5'h00,5'h00);
         8'h29: g = make_glyph(3'd2, 5'h00,5'h10,5'h08,5'h08,5'h08,5'h08,5'h10,5'h00,5'h00);
         8'h2B: g = make_glyph(3'd5, 5'h00,5'h00,5'h04,5'h04,5'h1f,5'h04,5'h04,5'h00,5'h00);
         8'h2D: g = make_glyph(3'd5, 5'h00,5'h00,5'h00,5'h00,5'h1f,5'h00,5'h00,5'h00,5'h00);
         8'h3D: g = make_glyph(3'd5, 5'h00,5'h00,5'h00,5'h1f,5'h00,5'h1f,5'h00,5'h00,5'h00);
         8'h23: g = make_glyph(3'd5, 5'h00,5'h00,5'h0a,5'h1f,5'h0a,5'h1f,5'h0a,5'h00,5'h00);
         8'h25: g = make_glyph(3'd5, 5'h00,5'h00,5'h19,5'h12,5'h04,5'h09,5'h13,5'h00,5'h00);
         8'h2A: g = make_glyph(3'd5, 5'h00,5'h04,5'h15,5'h0e,5'h1f,5'h0e,5'h15,5'h04,5'h00);
         8'h5C: g = make_glyph(3'd4, 5'h10,5'h10,5'h08,5'h08,5'h04,5'h04,5'h02,5'h02,5'h00);
         8'h2F: g = make_glyph(3'd4, 5'h02,5'h02,5'h04,5'h04,5'h08,5'h08,5'h10,5'h10,5'h00);
         8'h3A: g = make_glyph(3'd1, 5'h00,5'h00,5'h00,5'h10,5'h00,5'h10,5'h00,5'h00,5'h00);
         8'h3B: g = make_glyph(3'd1, 5'h00,5'h00,5'h00,5'h10,5'h00,5'h10,5'h10,5'h00,5'h00);
         8'h27: g = make_glyph(3'd1, 5'h00,5'h10,5'h10,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00);
         8'h26: g = make_glyph(3'd5, 5'h0c,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0d,5'h00,5'h00);
         8'hA3: g = make_glyph(3'd4, 5'h0c,5'h12,5'h10,5'h08,5'h1c,5'h08,5'h1e,5'h00,5'h00);
         8'h24: g = make_glyph(3'd5, 5'h00,5'h04,5'h0e,5'h14,5'h0e,5'h05,5'h0e,5'h04,5'h00);
         8'h3C: g = make_glyph(3'd4, 5'h00,5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02,5'h00);
         8'h3E: g = make_glyph(3'd4, 5'h00,5'h10,5'h08,5'h04,5'h02,5'h04,5'h08,5'h10,5'h00);
         8'h40: g = make_glyph(3'd5, 5'h00,5'h00,5'h0e,5'h11,5'h17,5'h16,5'h10,5'h0f,5'h00);
         8'h5F: g = make_glyph(3'd4, 5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1e,5'h00);
         // Question mark, also used for every code without a glyph.
         default: g = make_glyph(3'd4, 5'h0c,5'h12,5'h02,5'h0c,5'h08,5'h00,5'h08,5'h00,5'h00);
      endcase
      return g;
   endfunction

endpackage

// ===== hdl/btgb_layout.sv =====
// ----------------------------------------------------------------------------
// btgb_layout
// Glyph lookup, on-screen tests and cursor update for one held character.
// ----------------------------------------------------------------------------
module btgb_layout (
   input  btgb_pkg::req_item_type item,
   input  btgb_pkg::cursor_type   cursor,
   input  btgb_pkg::cfg_type      cfg,
   output btgb_pkg::plan_type     plan
);
   import btgb_pkg::*;

   localparam logic signed [COORD_W:0] Y_MIN = -(COORD_W+1)'(GLYPH_ROWS);
   localparam logic [COORD_W-1:0] TAB_MASK = ~(COORD_W'(TAB_STEP - 1));

   logic [COORD_W-1:0] cur_x;
   logic [COORD_W-1:0] cur_y;
   logic [COORD_W-1:0] line_x;
   logic               is_space;
   logic               is_tab;
   logic               is_newline;
   logic               draws;
   glyph_type          glyph;

   // True when a glyph origin lies inside the clipped screen area.
   function automatic logic on_screen(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input cfg_type c);
      logic signed [COORD_W:0] sx;
      logic signed [COORD_W:0] sy;
      logic signed [COORD_W:0] w;
      logic signed [COORD_W:0] h;
      logic signed [COORD_W:0] xmin;
      sx   = $signed({x[COORD_W-1], x});
      sy   = $signed({y[COORD_W-1], y});
      w    = $signed({{(COORD_W-12){1'b0}}, c.screen_width});
      h    = $signed({{(COORD_W-12){1'b0}}, c.screen_height});
      xmin = -$signed({{(COORD_W-4){1'b0}}, c.clip_width});
      return (sy >= Y_MIN) && (sy < h) && (sx >= xmin) && (sx < w);
   endfunction

   // A new message reloads the cursor before the character is handled.
   assign cur_x  = item.new_message ? item.start_x : cursor.cursor_x;
   assign cur_y  = item.new_message ? item.start_y : cursor.cursor_y;
   assign line_x = item.new_message ? item.start_x : cursor.line_start_x;

   assign is_space   = (item.character == CHAR_SPACE);
   assign is_tab     = (item.character == CHAR_TAB);
   assign is_newline = (item.character == CHAR_NEWLINE);
   assign draws      = !(is_space || is_tab || is_newline);
   assign glyph      = glyph_lookup(item.character);

   // Blit positions and visibility.
   always_comb begin
      plan.glyph          = glyph;
      plan.main_x         = cur_x;
      plan.main_y         = cur_y;
      plan.shadow_x       = cur_x + COORD_W'(1);
      plan.shadow_y       = cur_y + COORD_W'(1);
      plan.main_visible   = draws && on_screen(cur_x, cur_y, cfg);
      plan.shadow_visible = draws && item.shadow &&
                            on_screen(plan.shadow_x, plan.shadow_y, cfg);
   end

   // Cursor after this character; all steps wrap at 16 bits.
   always_comb begin
      plan.next_cursor.line_start_x = line_x;
      plan.next_cursor.cursor_y     = cur_y;
      if (is_space) begin
         plan.next_cursor.cursor_x = cur_x + COORD_W'(SPACE_ADVANCE);
      end else if (is_tab) begin
         // Floor to a multiple of the tab step in the two's complement sense.
         plan.next_cursor.cursor_x = (cur_x + COORD_W'(TAB_STEP)) & TAB_MASK;
      end else if (is_newline) begin
         plan.next_cursor.cursor_x = line_x;
         plan.next_cursor.cursor_y = cur_y + COORD_W'(LINE_ADVANCE);
      end else begin
         plan.next_cursor.cursor_x = cur_x + COORD_W'(glyph.width) + COORD_W'(1);
      end
   end

endmodule

// ===== hdl/bitmap_text_glyph_blitter_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_text_glyph_blitter_core
// Turns a stream of characters into 5x9 glyph blits with optional shadow.
// ----------------------------------------------------------------------------
// Each request carries one character. A drawn character gives up to two
// blits, the half-intensity shadow at (+1,+1) first and then the main glyph;
// a space, tab, newline or fully clipped glyph gives none and only moves the
// cursor. A request is held in one input register while its blits leave
// through the output register, one blit per cycle while the receiver takes
// them. The next request is taken in the same cycle the held one is
// finished; a waiting output blocks it while the held character still has
// a blit to send. Configuration writes apply at once and are meant for an
// idle block.
module bitmap_text_glyph_blitter_core (
   input  logic         clock,
   input  logic         reset,
   // new_message, start_x, start_y, red, green, blue, shadow, character, pad
   input  logic [71:0]  req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // blit_x, blit_y, glyph_bits, glyph_width, draw_red, draw_green, draw_blue
   output logic [103:0] rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [12:0]  csr_wdata
);
   import btgb_pkg::*;

   cfg_type      cfg_ff;
   cursor_type   cursor_ff;
   req_item_type item_ff;
   req_item_type item_in;
   logic         item_valid_ff;
   logic         shadow_done_ff;
   blit_type     out_ff;
   logic         out_valid_ff;
   plan_type     plan;
   logic         req_accept;
   logic         out_free;
   logic         send_shadow;
   logic         need_out;
   logic         load_out;
   logic         consume;

   // Unpack the request payload.
   always_comb begin
      item_in.new_message = req_tdata[0];
      item_in.start_x     = req_tdata[16:1];
      item_in.start_y     = req_tdata[32:17];
      item_in.red         = req_tdata[40:33];
      item_in.green       = req_tdata[48:41];
      item_in.blue        = req_tdata[56:49];
      item_in.shadow      = req_tdata[57];
      item_in.character   = req_tdata[65:58];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RESET;
         cfg_ff.clip_width    <= CLIP_WIDTH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wdata;
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wdata;
            CSR_CLIP_WIDTH:    cfg_ff.clip_width    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   btgb_layout u_layout (
      .item   (item_ff),
      .cursor (cursor_ff),
      .cfg    (cfg_ff),
      .plan   (plan)
   );

   // Blit sequencing: shadow first when due, then main.
   assign out_free    = !out_valid_ff || rsp_tready;
   assign send_shadow = !shadow_done_ff && plan.shadow_visible;
   assign need_out    = item_valid_ff && (send_shadow || plan.main_visible);
   assign load_out    = need_out && out_free;
   assign consume     = item_valid_ff && (!need_out || out_free) &&
                        !(send_shadow && plan.main_visible);
   assign req_tready  = !item_valid_ff || consume;
   assign req_accept  = req_tvalid && req_tready;

   // Held request and cursor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff  <= 1'b0;
         shadow_done_ff <= 1'b0;
         cursor_ff      <= '0;
      end else begin
         if (req_accept) begin
            item_valid_ff <= 1'b1;
         end else if (consume) begin
            item_valid_ff <= 1'b0;
         end
         if (consume) begin
            shadow_done_ff <= 1'b0;
            cursor_ff      <= plan.next_cursor;
         end else if (load_out && send_shadow) begin
            shadow_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff.glyph_bits  <= plan.glyph.bits;
         out_ff.glyph_width <= plan.glyph.width;
         if (send_shadow) begin
            out_ff.blit_x     <= plan.shadow_x;
            out_ff.blit_y     <= plan.shadow_y;
            out_ff.draw_red   <= {1'b0, item_ff.red[7:1]};
            out_ff.draw_green <= {1'b0, item_ff.green[7:1]};
            out_ff.draw_blue  <= {1'b0, item_ff.blue[7:1]};
            out_ff.last       <= !plan.main_visible;
         end else begin
            out_ff.blit_x     <= plan.main_x;
            out_ff.blit_y     <= plan.main_y;
            out_ff.draw_red   <= item_ff.red;
            out_ff.draw_green <= item_ff.green;
            out_ff.draw_blue  <= item_ff.blue;
            out_ff.last       <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {out_ff.draw_blue, out_ff.draw_green, out_ff.draw_red,
                        out_ff.glyph_width, out_ff.glyph_bits,
                        out_ff.blit_y, out_ff.blit_x};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 5x9 bitmap text glyph blitter.
// ----------------------------------------------------------------------------
// Characters are streamed in as requests: first a short directed list that
// covers the control characters, unknown codes, shadow clipping on every
// screen edge and 16-bit cursor wrap. After that come randomized messages
// over a range of screen and clip settings. A scoreboard keeps its own pen
// state and font table and checks every blit field against the expected
// blits in arrival order. Both stream sides idle at random, and one phase
// stalls the result side long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
   import btgb_pkg::*;

   localparam int RSP_HOLDOFF    = 400;
   // Longest quiet stretch of a correct run is the result hold-off plus the
   // block latency; the limit is ten times the hold-off.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int PHASE_COUNT    = 9;
   localparam int PHASE_REQUESTS = 210;

   // -------------------------------------------------------------------------
   // Scoreboard: pen state, registers and the queue of expected blits.
   // -------------------------------------------------------------------------
   class blit_scoreboard;
      localparam int PEN_SPACE = 4;
      localparam int PEN_TAB   = 16;
      localparam int PEN_LINE  = 10;
      localparam int ROWS      = 9;

      logic [15:0] pen_x, pen_y, margin_x;
      logic [12:0] scr_w, scr_h;
      logic [4:0]  clip;
      blit_type    pending_blits[$];
      int unsigned fail_count;

      function new();
         pen_x      = '0;
         pen_y      = '0;
         margin_x   = '0;
         scr_w      = 13'd640;
         scr_h      = 13'd480;
         clip       = 5'd5;
         fail_count = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [12:0] value);
         case (idx)
            CSR_SCREEN_WIDTH:  scr_w = value;
            CSR_SCREEN_HEIGHT: scr_h = value;
            CSR_CLIP_WIDTH:    clip  = value[4:0];
            default: ;
         endcase
      endfunction

      // Font table, rows listed top row first, one byte per row.
      function void font_lookup(input logic [7:0] c, output logic [2:0] w,
                                output logic [44:0] bits);
         logic [71:0] rows;
         case (c)
            8'h41: begin w = 4; rows = 72'h0c_12_12_12_1e_12_12_00_00; end
            8'h42: begin w = 4; rows = 72'h1c_12_12_1c_12_12_1c_00_00; end
            8'h43: begin w = 4; rows = 72'h0e_10_10_10_10_10_0e_00_00; end
            8'h44: begin w = 4; rows = 72'h1c_12_12_12_12_12_1c_00_00; end
            8'h45: begin w = 4; rows = 72'h1e_10_10_1c_10_10_1e_00_00; end
            8'h46: begin w = 4; rows = 72'h1e_10_10_1c_10_10_10_00_00; end
            8'h47: begin w = 4; rows = 72'h0e_10_10_10_16_12_0e_00_00; end
            8'h48: begin w = 4; rows = 72'h12_12_12_1e_12_12_12_00_00; end
            8'h49: begin w = 3; rows = 72'h1c_08_08_08_08_08_1c_00_00; end
            8'h4A: begin w = 4; rows = 72'h1e_02_02_02_02_12_0c_00_00; end
            8'h4B: begin w = 4; rows = 72'h10_12_14_18_18_14_12_00_00; end
            8'h4C: begin w = 4; rows = 72'h10_10_10_10_10_10_1e_00_00; end
            8'h4D: begin w = 5; rows = 72'h11_1b_15_11_11_11_11_00_00; end
            8'h4E: begin w = 5; rows = 72'h11_11_19_15_13_11_11_00_00; end
            8'h4F: begin w = 4; rows = 72'h0c_12_12_12_12_12_0c_00_00; end
            8'h50: begin w = 4; rows = 72'h1c_12_12_12_1c_10_10_00_00; end
            8'h51: begin w = 4; rows = 72'h0c_12_12_12_12_16_0c_02_00; end
            8'h52: begin w = 4; rows = 72'h1c_12_12_12_1c_14_12_00_00; end
            8'h53: begin w = 4; rows = 72'h0c_12_10_08_04_12_0c_00_00; end
            8'h54: begin w = 3; rows = 72'h1c_08_08_08_08_08_08_00_00; end
            8'h55: begin w = 4; rows = 72'h12_12_12_12_12_12_0c_00_00; end
            8'h56: begin w = 4; rows = 72'h12_12_12_12_12_0a_06_00_00; end
            8'h57: begin w = 5; rows = 72'h11_11_11_11_15_1b_11_00_00; end
            8'h58: begin w = 5; rows = 72'h11_11_0a_04_0a_11_11_00_00; end
            8'h59: begin w = 4; rows = 72'h12_12_12_0a_06_04_18_00_00; end
            8'h5A: begin w = 4; rows = 72'h1e_02_02_04_08_10_1e_00_00; end
            8'h61: begin w = 4; rows = 72'h00_00_0c_02_0e_12_0e_00_00; end
            8'h62: begin w = 4; rows = 72'h00_10_1c_12_12_12_1c_00_00; end
            8'h63: begin w = 3; rows = 72'h00_00_0c_10_10_10_0c_00_00; end
            8'h64: begin w = 4; rows = 72'h00_02_0e_12_12_12_0e_00_00; end
            8'h65: begin w = 4; rows = 72'h00_00_0c_12_1e_10_0e_00_00; end
            8'h66: begin w = 3; rows = 72'h00_0c_10_10_18_10_10_00_00; end
            8'h67: begin w = 4; rows = 72'h00_00_0e_12_12_12_0e_02_0c; end
            8'h68: begin w = 4; rows = 72'h00_10_10_1c_12_12_12_00_00; end
            8'h69: begin w = 2; rows = 72'h00_08_00_18_08_08_08_00_00; end
            8'h6A: begin w = 2; rows = 72'h00_08_00_18_08_08_08_08_10; end
            8'h6B: begin w = 3; rows = 72'h00_10_10_10_14_18_14_00_00; end
            8'h6C: begin w = 2; rows = 72'h00_18_08_08_08_08_08_00_00; end
            8'h6D: begin w = 5; rows = 72'h00_00_1a_15_11_11_11_00_00; end
            8'h6E: begin w = 4; rows = 72'h00_00_1c_12_12_12_12_00_00; end
            8'h6F: begin w = 4; rows = 72'h00_00_0c_12_12_12_0c_00_00; end
            8'h70: begin w = 4; rows = 72'h00_00_1c_12_12_12_1c_10_10; end
            8'h71: begin w = 4; rows = 72'h00_00_0e_12_12_12_0e_03_02; end
            8'h72: begin w = 4; rows = 72'h00_00_16_18_10_10_10_00_00; end
            8'h73: begin w = 4; rows = 72'h00_00_0e_10_0c_02_1c_00_00; end
            8'h74: begin w = 3; rows = 72'h00_10_10_1c_10_10_0c_00_00; end
            8'h75: begin w = 4; rows = 72'h00_00_12_12_12_12_0e_00_00; end
            8'h76: begin w = 4; rows = 72'h00_00_12_12_12_0a_06_00_00; end
            8'h77: begin w = 5; rows = 72'h00_00_11_11_11_15_0a_00_00; end
            8'h78: begin w = 5; rows = 72'h00_00_11_0a_04_0a_11_00_00; end
            8'h79: begin w = 4; rows = 72'h00_00_12_12_12_12_0e_02_0c; end
            8'h7A: begin w = 4; rows = 72'h00_00_1e_02_04_08_1e_00_00; end
            8'h30: begin w = 4; rows = 72'h0c_12_16_1a_12_12_0c_00_00; end
            8'h31: begin w = 3; rows = 72'h08_18_08_08_08_08_1c_00_00; end
            8'h32: begin w = 4; rows = 72'h0c_12_02_04_08_10_1e_00_00; end
            8'h33: begin w = 4; rows = 72'h0c_12_02_04_02_12_0c_00_00; end
            8'h34: begin w = 4; rows = 72'h04_0c_14_14_1e_04_04_00_00; end
            8'h35: begin w = 4; rows = 72'h1e_10_10_1c_02_02_1c_00_00; end
            8'h36: begin w = 4; rows = 72'h04_08_10_1c_12_12_0c_00_00; end
            8'h37: begin w = 4; rows = 72'h1e_02_02_04_08_08_08_00_00; end
            8'h38: begin w = 4; rows = 72'h0c_12_12_0c_12_12_0c_00_00; end
            8'h39: begin w = 4; rows = 72'h0c_12_12_0e_02_02_0c_00_00; end
            8'h2E: begin w = 1; rows = 72'h00_00_00_00_00_00_10_00_00; end
            8'h2C: begin w = 2; rows = 72'h00_00_00_00_00_00_10_10_00; end
            8'h21: begin w = 1; rows = 72'h10_10_10_10_10_00_10_00_00; end
            8'h22: begin w = 3; rows = 72'h14_14_00_00_00_00_00_00_00; end
            8'h28: begin w = 2; rows = 72'h00_08_10_10_10_10_08_00_00; end
            8'h29: begin w = 2; rows = 72'h00_10_08_08_08_08_10_00_00; end
            8'h2B: begin w = 5; rows = 72'h00_00_04_04_1f_04_04_00_00; end
            8'h2D: begin w = 5; rows = 72'h00_00_00_00_1f_00_00_00_00; end
            8'h3D: begin w = 5; rows = 72'h00_00_00_1f_00_1f_00_00_00; end
            8'h23: begin w = 5; rows = 72'h00_00_0a_1f_0a_1f_0a_00_00; end
            8'h25: begin w = 5; rows = 72'h00_00_19_12_04_09_13_00_00; end
            8'h2A: begin w = 5; rows = 72'h00_04_15_0e_1f_0e_15_04_00; end
            8'h5C: begin w = 4; rows = 72'h10_10_08_08_04_04_02_02_00; end
            8'h2F: begin w = 4; rows = 72'h02_02_04_04_08_08_10_10_00; end
            8'h3A: begin w = 1; rows = 72'h00_00_00_10_00_10_00_00_00; end
            8'h3B: begin w = 1; rows = 72'h00_00_00_10_00_10_10_00_00; end
            8'h27: begin w = 1; rows = 72'h00_10_10_00_00_00_00_00_00; end
            8'h26: begin w = 5; rows = 72'h0c_12_14_08_15_12_0d_00_00; end
            8'hA3: begin w = 4; rows = 72'h0c_12_10_08_1c_08_1e_00_00; end
            8'h24: begin w = 5; rows = 72'h00_04_0e_14_0e_05_0e_04_00; end
            8'h3C: begin w = 4; rows = 72'h00_02_04_08_10_08_04_02_00; end
            8'h3E: begin w = 4; rows = 72'h00_10_08_04_02_04_08_10_00; end
            8'h40: begin w = 5; rows = 72'h00_00_0e_11_17_16_10_0f_00; end
            8'h5F: begin w = 4; rows = 72'h00_00_00_00_00_00_00_1e_00; end
            // Question mark stands in for every code without a glyph.
            default: begin w = 4; rows = 72'h0c_12_02_0c_08_00_08_00_00; end
         endcase
         for (int i = 0; i < ROWS; i++)
            bits[5*i +: 5] = rows[64-8*i +: 5];
      endfunction

      // A blit is drawn only when its origin falls inside the clip window.
      function bit on_screen(logic [15:0] x, logic [15:0] y);
         int sx, sy;
         sx = $signed(x);
         sy = $signed(y);
         if (sy < -ROWS || sy >= int'(scr_h)) return 0;
         if (sx < -int'(clip) || sx >= int'(scr_w)) return 0;
         return 1;
      endfunction

      // Advances the pen for one accepted request and queues its blits.
      function void note_char(req_item_type q);
         logic [2:0]  w;
         logic [44:0] bits;
         logic [15:0] sx, sy;
         bit          shadow_vis, main_vis;
         blit_type    b;
         if (q.new_message) begin
            pen_x    = q.start_x;
            margin_x = q.start_x;
            pen_y    = q.start_y;
         end
         case (q.character)
            CHAR_SPACE:   pen_x = pen_x + 16'(PEN_SPACE);
            CHAR_TAB:     pen_x = (pen_x + 16'(PEN_TAB)) & ~16'(PEN_TAB - 1);
            CHAR_NEWLINE: begin
               pen_x = margin_x;
               pen_y = pen_y + 16'(PEN_LINE);
            end
            default: begin
               font_lookup(q.character, w, bits);
               sx         = pen_x + 16'd1;
               sy         = pen_y + 16'd1;
               shadow_vis = q.shadow && on_screen(sx, sy);
               main_vis   = on_screen(pen_x, pen_y);
               b.glyph_bits  = bits;
               b.glyph_width = w;
               if (shadow_vis) begin
                  b.blit_x     = sx;
                  b.blit_y     = sy;
                  b.draw_red   = q.red >> 1;
                  b.draw_green = q.green >> 1;
                  b.draw_blue  = q.blue >> 1;
                  b.last       = !main_vis;
                  pending_blits.push_back(b);
               end
               if (main_vis) begin
                  b.blit_x     = pen_x;
                  b.blit_y     = pen_y;
                  b.draw_red   = q.red;
                  b.draw_green = q.green;
                  b.draw_blue  = q.blue;
                  b.last       = 1'b1;
                  pending_blits.push_back(b);
               end
               pen_x = pen_x + 16'(w) + 16'd1;
            end
         endcase
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_blit(blit_type got);
         blit_type want;
         if (pending_blits.size() == 0) begin
            $error("blit with none expected: x=%0h y=%0h", got.blit_x, got.blit_y);
            fail_count++;
            return;
         end
         want = pending_blits.pop_front();
         check_field("blit_x", want.blit_x, got.blit_x);
         check_field("blit_y", want.blit_y, got.blit_y);
         check_field("glyph_bits", want.glyph_bits, got.glyph_bits);
         check_field("glyph_width", want.glyph_width, got.glyph_width);
         check_field("draw_red", want.draw_red, got.draw_red);
         check_field("draw_green", want.draw_green, got.draw_green);
         check_field("draw_blue", want.draw_blue, got.draw_blue);
         check_field("last", want.last, got.last);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and the block.
   // -------------------------------------------------------------------------
   logic         clock;
   logic         reset;
   logic [71:0]  req_tdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_we;
   logic [1:0]   csr_addr;
   logic [12:0]  csr_wdata;

   blit_scoreboard sb;
   bit             steady;      // no random idling on either side while set
   bit             hold_rsp;    // asks the receiver for one long stall
   int unsigned    quiet_cycles;
   int unsigned    sent_count;
   blit_type       seen_blit;

   bitmap_text_glyph_blitter_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned gap_len();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [71:0] pack_request(req_item_type q);
      return {6'd0, q.character, q.shadow, q.blue, q.green, q.red,
              q.start_y, q.start_x, q.new_message};
   endfunction

   // -------------------------------------------------------------------------
   // Request side.
   // -------------------------------------------------------------------------
   task automatic send_request(req_item_type q);
      int unsigned gap;
      gap = steady ? 0 : gap_len();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = pack_request(q);
      do @(posedge clock); while (!req_tready);
      sb.note_char(q);
      sent_count++;
   endtask

   task automatic send_char(bit nm, logic [15:0] x, logic [15:0] y, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b, bit sh, logic [7:0] c);
      req_item_type q;
      q.new_message = nm;
      q.start_x     = x;
      q.start_y     = y;
      q.red         = r;
      q.green       = g;
      q.blue        = b;
      q.shadow      = sh;
      q.character   = c;
      send_request(q);
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 70) return 8'($urandom_range(8'h21, 8'h7E));
      if (p < 80) return CHAR_SPACE;
      if (p < 85) return CHAR_TAB;
      if (p < 90) return CHAR_NEWLINE;
      return 8'($urandom_range(0, 255));
   endfunction

   // One message: a start request, then text in one colour and shadow mode.
   // Some items are pure noise, and continuation items carry junk positions.
   task automatic send_message();
      req_item_type q;
      int           len, x, y, p;
      len = $urandom_range(1, 24);
      p   = $urandom_range(0, 99);
      if (p < 10) begin
         x = $urandom_range(0, 65535);
         y = $urandom_range(0, 65535);
      end else if (p < 15) begin
         x = 32767 - $urandom_range(0, 40);
         y = $urandom_range(0, 20);
      end else begin
         x = int'($urandom_range(0, int'(sb.scr_w) + 24)) - 20;
         y = int'($urandom_range(0, int'(sb.scr_h) + 14)) - 14;
      end
      q.red    = 8'($urandom);
      q.green  = 8'($urandom);
      q.blue   = 8'($urandom);
      q.shadow = $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
         q.new_message = (i == 0);
         q.start_x     = (i == 0) ? 16'(x) : 16'($urandom);
         q.start_y     = (i == 0) ? 16'(y) : 16'($urandom);
         q.character   = pick_char();
         if ($urandom_range(0, 99) < 6)
            send_char($urandom_range(0, 1), 16'($urandom), 16'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), $urandom_range(0, 1), 8'($urandom));
         else
            send_request(q);
      end
   endtask

   // Register writes happen only with nothing in flight.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending_blits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [12:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic apply_setting(int ph);
      case (ph)
         0: begin
            write_reg(CSR_SCREEN_WIDTH, 13'd640);
            write_reg(CSR_SCREEN_HEIGHT, 13'd480);
            write_reg(CSR_CLIP_WIDTH, 13'd5);
         end
         1: begin
            write_reg(CSR_SCREEN_WIDTH, 13'd1);
            write_reg(CSR_SCREEN_HEIGHT, 13'd1);
            write_reg(CSR_CLIP_WIDTH, 13'd0);
         end
         2: begin
            write_reg(CSR_SCREEN_WIDTH, 13'h1FFF);
            write_reg(CSR_SCREEN_HEIGHT, 13'h1FFF);
            write_reg(CSR_CLIP_WIDTH, 13'd31);
         end
         3: begin
            write_reg(CSR_SCREEN_WIDTH, 13'd4096);
            write_reg(CSR_SCREEN_HEIGHT, 13'd4096);
            write_reg(CSR_CLIP_WIDTH, 13'd16);
         end
         4: begin
            write_reg(CSR_SCREEN_WIDTH, 13'd0);
            write_reg(CSR_SCREEN_HEIGHT, 13'd0);
            write_reg(CSR_CLIP_WIDTH, 13'($urandom));
         end
         5: begin
            write_reg(CSR_SCREEN_WIDTH, 13'($urandom_range(1, 200)));
            write_reg(CSR_SCREEN_HEIGHT, 13'($urandom_range(1, 120)));
            write_reg(CSR_CLIP_WIDTH, 13'($urandom_range(0, 31)));
         end
         6: begin
            write_reg(CSR_SCREEN_WIDTH, 13'd320);
            write_reg(CSR_SCREEN_HEIGHT, 13'd200);
            // Upper write-data bits are don't-care for the clip register.
            write_reg(CSR_CLIP_WIDTH, 13'h1FE0 | 13'($urandom_range(0, 31)));
         end
         7: begin
            write_reg(CSR_SCREEN_WIDTH, 13'($urandom));
            write_reg(CSR_SCREEN_HEIGHT, 13'($urandom));
            write_reg(CSR_CLIP_WIDTH, 13'($urandom));
         end
         default: begin
            write_reg(CSR_SCREEN_WIDTH, 13'd640);
            write_reg(CSR_SCREEN_HEIGHT, 13'd480);
            write_reg(CSR_CLIP_WIDTH, 13'd5);
         end
      endcase
   endtask

   // Edge cases on the reset-time screen of 640x480 with clip 5.
   task automatic run_directed();
      send_char(1, 16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF, 1, 8'h41);
      send_char(0, 16'hFFFF, 16'hFFFF, 8'h00, 8'h80, 8'h01, 0, 8'h7A);
      send_char(0, 16'd0, 16'd0, 8'h01, 8'hFE, 8'h55, 1, 8'h30);
      send_char(0, 16'd0, 16'd0, 8'hAA, 8'h55, 8'h0F, 1, 8'h39);
      send_char(0, 16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF, 1, CHAR_SPACE);
      send_char(0, 16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF, 1, CHAR_TAB);
      send_char(0, 16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF, 1, CHAR_NEWLINE);
      send_char(0, 16'd0, 16'd0, 8'h12, 8'h34, 8'h56, 0, 8'h00);
      send_char(0, 16'd0, 16'd0, 8'h12, 8'h34, 8'h56, 1, 8'h7F);
      send_char(0, 16'd0, 16'd0, 8'h12, 8'h34, 8'h56, 0, 8'hFF);
      send_char(0, 16'd0, 16'd0, 8'h12, 8'h34, 8'h56, 1, 8'hA3);
      send_char(0, 16'd0, 16'd0, 8'h12, 8'h34, 8'h56, 0, 8'h0D);
      // Main blit exactly on the top-left clip limits, shadow just inside them.
      send_char(1, -16'sd5, -16'sd9, 8'h80, 8'h81, 8'h7F, 1, 8'h4D);
      // Main blit left of the clip window, only the shadow shows.
      send_char(1, -16'sd6, 16'd0, 8'h80, 8'h81, 8'h7F, 1, 8'h57);
      // Shadow off the bottom-right corner, only the main blit shows.
      send_char(1, 16'd639, 16'd479, 8'h80, 8'h81, 8'h7F, 1, 8'h40);
      send_char(1, 16'd640, 16'd0, 8'h80, 8'h81, 8'h7F, 1, 8'h78);
      // Shadow position wraps to the most negative coordinate.
      send_char(1, 16'h7FFF, 16'h7FFF, 8'h80, 8'h81, 8'h7F, 1, 8'h23);
      send_char(1, 16'h8000, 16'h8000, 8'h80, 8'h81, 8'h7F, 0, 8'h6A);
      // Tab from a negative column moves on to the next multiple of the tab step.
      send_char(1, -16'sd17, 16'd3, 8'h11, 8'h22, 8'h33, 0, CHAR_TAB);
      send_char(0, 16'd0, 16'd0, 8'h11, 8'h22, 8'h33, 0, 8'h21);
      send_char(1, 16'd5, 16'd20, 8'h11, 8'h22, 8'h33, 0, 8'h5F);
      send_char(0, 16'd0, 16'd0, 8'h11, 8'h22, 8'h33, 0, CHAR_NEWLINE);
      send_char(0, 16'd0, 16'd0, 8'h11, 8'h22, 8'h33, 1, 8'h2A);
      // Main blit above the top limit, shadow just inside it.
      send_char(1, 16'd0, -16'sd10, 8'hFE, 8'h01, 8'hFF, 1, 8'h67);
      send_char(1, 16'd0, 16'd470, 8'hFE, 8'h01, 8'hFF, 1, 8'h3F);
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stalls, one long hold-off on request.
   // -------------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (RSP_HOLDOFF) @(negedge clock);
            hold_rsp = 0;
         end
         if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat (gap_len()) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_blit.blit_x      = rsp_tdata[15:0];
         seen_blit.blit_y      = rsp_tdata[31:16];
         seen_blit.glyph_bits  = rsp_tdata[76:32];
         seen_blit.glyph_width = rsp_tdata[79:77];
         seen_blit.draw_red    = rsp_tdata[87:80];
         seen_blit.draw_green  = rsp_tdata[95:88];
         seen_blit.draw_blue   = rsp_tdata[103:96];
         seen_blit.last        = rsp_tlast;
         sb.check_blit(seen_blit);
      end
   end

   // Watchdog on stretches with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bitmap_text_glyph_blitter_core verification failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      steady     = 0;
      hold_rsp   = 0;
      sent_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      drain();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         apply_setting(ph);
         steady     = (ph == 3) || ($urandom_range(0, 3) == 0);
         hold_rsp   = (ph == 3);
         sent_count = 0;
         while (sent_count < PHASE_REQUESTS) send_message();
         drain();
      end

      if (sb.fail_count == 0)
         $display("bitmap_text_glyph_blitter_core verification clean");
      else
         $display("bitmap_text_glyph_blitter_core verification failed");
      $finish;
   end

endmodule
